// ===== rtl/lca_binary_lifting_unit_defines.svh =====
// Assertion macros shared by the lowest common ancestor unit.
`ifndef LCA_BINARY_LIFTING_UNIT_DEFINES_SVH
`define LCA_BINARY_LIFTING_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCABL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCABL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcabl_pkg.sv =====
package lcabl_pkg;

  localparam int NODE_W = 10;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_BUILT  = 1'b1;

  localparam int ACT_W  = 5;
  localparam int COND_W = 3;
  localparam int PC_W   = 5;

  localparam logic [ACT_W-1:0] ACT_NOP     = 5'd0;
  localparam logic [ACT_W-1:0] ACT_WRAP_Q  = 5'd1;
  localparam logic [ACT_W-1:0] ACT_WRAP_R  = 5'd2;
  localparam logic [ACT_W-1:0] ACT_LOAD    = 5'd3;
  localparam logic [ACT_W-1:0] ACT_RD_DA   = 5'd4;
  localparam logic [ACT_W-1:0] ACT_RD_DB   = 5'd5;
  localparam logic [ACT_W-1:0] ACT_ORDER   = 5'd6;
  localparam logic [ACT_W-1:0] ACT_LIFT_RD = 5'd7;
  localparam logic [ACT_W-1:0] ACT_LIFT_WB = 5'd8;
  localparam logic [ACT_W-1:0] ACT_EQ_CHK  = 5'd9;
  localparam logic [ACT_W-1:0] ACT_JRD_A   = 5'd10;
  localparam logic [ACT_W-1:0] ACT_JRD_B   = 5'd11;
  localparam logic [ACT_W-1:0] ACT_JUMP    = 5'd12;
  localparam logic [ACT_W-1:0] ACT_FIN_RD  = 5'd13;
  localparam logic [ACT_W-1:0] ACT_FIN_OUT = 5'd14;
  localparam logic [ACT_W-1:0] ACT_OUT_A   = 5'd15;
  localparam logic [ACT_W-1:0] ACT_BINIT   = 5'd16;
  localparam logic [ACT_W-1:0] ACT_BRD1    = 5'd17;
  localparam logic [ACT_W-1:0] ACT_BRD2    = 5'd18;
  localparam logic [ACT_W-1:0] ACT_BWR     = 5'd19;
  localparam logic [ACT_W-1:0] ACT_BNEXT   = 5'd20;
  localparam logic [ACT_W-1:0] ACT_BDONE   = 5'd21;

  localparam logic [COND_W-1:0] COND_NEXT      = 3'd0;
  localparam logic [COND_W-1:0] COND_END       = 3'd1;
  localparam logic [COND_W-1:0] COND_IS_LOAD   = 3'd2;
  localparam logic [COND_W-1:0] COND_LVL_NZ    = 3'd3;
  localparam logic [COND_W-1:0] COND_A_EQ_B    = 3'd4;
  localparam logic [COND_W-1:0] COND_J_NLAST   = 3'd5;
  localparam logic [COND_W-1:0] COND_LVL_NLAST = 3'd6;
  localparam logic [COND_W-1:0] COND_ONE_LEVEL = 3'd7;

  localparam logic [PC_W-1:0] PC_ENTRY = 5'd0;
  localparam logic [PC_W-1:0] PC_LIFT  = 5'd5;
  localparam logic [PC_W-1:0] PC_JUMPS = 5'd8;
  localparam logic [PC_W-1:0] PC_OUT_A = 5'd13;
  localparam logic [PC_W-1:0] PC_LOAD  = 5'd15;
  localparam logic [PC_W-1:0] PC_BUILD = 5'd16;
  localparam logic [PC_W-1:0] PC_BLOOP = 5'd17;
  localparam logic [PC_W-1:0] PC_BDONE = 5'd21;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{act: ACT_NOP, cond: COND_END, target: PC_ENTRY};
    case (pc)
      5'd0:  w = '{act: ACT_WRAP_Q,  cond: COND_NEXT,      target: PC_ENTRY};
      5'd1:  w = '{act: ACT_WRAP_R,  cond: COND_IS_LOAD,   target: PC_LOAD};
      5'd2:  w = '{act: ACT_RD_DA,   cond: COND_NEXT,      target: PC_ENTRY};
      5'd3:  w = '{act: ACT_RD_DB,   cond: COND_NEXT,      target: PC_ENTRY};
      5'd4:  w = '{act: ACT_ORDER,   cond: COND_NEXT,      target: PC_ENTRY};
      5'd5:  w = '{act: ACT_LIFT_RD, cond: COND_NEXT,      target: PC_ENTRY};
      5'd6:  w = '{act: ACT_LIFT_WB, cond: COND_LVL_NZ,    target: PC_LIFT};
      5'd7:  w = '{act: ACT_EQ_CHK,  cond: COND_A_EQ_B,    target: PC_OUT_A};
      5'd8:  w = '{act: ACT_JRD_A,   cond: COND_NEXT,      target: PC_ENTRY};
      5'd9:  w = '{act: ACT_JRD_B,   cond: COND_NEXT,      target: PC_ENTRY};
      5'd10: w = '{act: ACT_JUMP,    cond: COND_LVL_NZ,    target: PC_JUMPS};
      5'd11: w = '{act: ACT_FIN_RD,  cond: COND_NEXT,      target: PC_ENTRY};
      5'd12: w = '{act: ACT_FIN_OUT, cond: COND_END,       target: PC_ENTRY};
      5'd13: w = '{act: ACT_OUT_A,   cond: COND_END,       target: PC_ENTRY};
      5'd15: w = '{act: ACT_LOAD,    cond: COND_END,       target: PC_ENTRY};
      5'd16: w = '{act: ACT_BINIT,   cond: COND_ONE_LEVEL, target: PC_BDONE};
      5'd17: w = '{act: ACT_BRD1,    cond: COND_NEXT,      target: PC_ENTRY};
      5'd18: w = '{act: ACT_BRD2,    cond: COND_NEXT,      target: PC_ENTRY};
      5'd19: w = '{act: ACT_BWR,     cond: COND_J_NLAST,   target: PC_BLOOP};
      5'd20: w = '{act: ACT_BNEXT,   cond: COND_LVL_NLAST, target: PC_BLOOP};
      5'd21: w = '{act: ACT_BDONE,   cond: COND_END,       target: PC_ENTRY};
      default: w = '{act: ACT_NOP, cond: COND_END, target: PC_ENTRY};
    endcase
    ucode_rom = w;
  endfunction

endpackage

// ===== rtl/lcabl_ram.sv =====
module lcabl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lca_binary_lifting_unit.sv =====
// Lowest common ancestor unit using binary lifting over a stored ancestor table.
// Command channel: a beat is taken when start is high and busy is low. Opcode 0
// loads one node (parent in in_other_node, depth in in_node_depth), opcode 1
// builds the ancestor levels above level 0, opcode 2 queries the common ancestor
// of in_node and in_other_node, and opcode 3 is ignored. Busy stays high until
// the command is finished.
// Result channel: out_valid marks a one-cycle beat carrying out_result_kind and
// out_answer_node; the receiver cannot stall and must take it in that cycle.
// A load gives no result. A query's length is set by one ancestor read per
// level while lifting and two serial ancestor reads and a compare per level
// while both nodes jump; a pair that meets after lifting ends without jumps.
// A build's length is set by the dependent read-read-write chain for each
// table entry on the single read port of the ancestor memory. Each result
// beat comes in the first cycle with busy low.
// Synchronous reset returns the sequencer to idle and drops out_valid; the
// depth and ancestor memories are not cleared and must be loaded before use.
module lca_binary_lifting_unit #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lcabl_pkg::OP_W-1:0]     in_opcode,
  input  logic [lcabl_pkg::NODE_W-1:0]   in_node,
  input  logic [lcabl_pkg::NODE_W-1:0]   in_other_node,
  input  logic [lcabl_pkg::NODE_W-1:0]   in_node_depth,
  output logic                           out_valid,
  output logic                           out_result_kind,
  output logic [lcabl_pkg::NODE_W-1:0]   out_answer_node
);

  localparam int NW     = lcabl_pkg::NODE_W;
  localparam int IW     = $clog2(NODES);
  localparam int AAW    = $clog2(LEVELS * NODES);
  localparam int LVLW   = $clog2(LEVELS + 1);
  localparam int WRAP_M = (2 ** 20 + NODES - 1) / NODES;

  localparam logic [AAW-1:0]  NODES_A  = AAW'(NODES);
  localparam logic [IW-1:0]   J_LAST   = IW'(NODES - 1);
  localparam logic [LVLW-1:0] LVL_TOP  = LVLW'(LEVELS - 1);
  localparam logic [NW-1:0]   NODES_NW = NW'(NODES);

  function automatic logic [AAW-1:0] anc_addr(input logic [LVLW-1:0] l,
                                              input logic [IW-1:0] n);
    anc_addr = AAW'(l) * NODES_A + AAW'(n);
  endfunction

  logic                       busy_r, busy_nxt;
  logic [lcabl_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                       is_load_r, is_load_nxt;
  logic [NW-1:0]              x_r, x_nxt;
  logic [NW-1:0]              y_r, y_nxt;
  logic [NW-1:0]              dep_in_r, dep_in_nxt;
  logic [NW-1:0]              qa_r, qa_nxt;
  logic [NW-1:0]              qb_r, qb_nxt;
  logic [NW-1:0]              a_r, a_nxt;
  logic [NW-1:0]              b_r, b_nxt;
  logic [NW-1:0]              t_r, t_nxt;
  logic [NW-1:0]              da_r, da_nxt;
  logic [NW-1:0]              diff_r, diff_nxt;
  logic [LVLW-1:0]            lvl_r, lvl_nxt;
  logic [IW-1:0]              j_r, j_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_kind_r, out_kind_nxt;
  logic [NW-1:0]              out_node_r, out_node_nxt;

  lcabl_pkg::ucode_t uw;
  logic              take;
  logic              jump;
  logic [30:0]       prod_a, prod_b;
  logic [NW-1:0]     diff_sh;
  logic [LVLW-1:0]   lvl_m1;

  logic           dep_we;
  logic [IW-1:0]  dep_raddr;
  logic [NW-1:0]  dep_rdata;
  logic           anc_we;
  logic [AAW-1:0] anc_waddr;
  logic [NW-1:0]  anc_wdata;
  logic [AAW-1:0] anc_raddr;
  logic [NW-1:0]  anc_rdata;

  lcabl_ram #(.WIDTH(NW), .DEPTH(NODES)) u_depth_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (IW'(a_r)),
    .wdata (dep_in_r),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  lcabl_ram #(.WIDTH(NW), .DEPTH(LEVELS * NODES)) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_rdata)
  );

  assign uw      = lcabl_pkg::ucode_rom(pc_r);
  assign take    = start && !busy_r && (in_opcode != lcabl_pkg::OP_NONE);
  assign prod_a  = 31'(x_r) * 31'(WRAP_M);
  assign prod_b  = 31'(y_r) * 31'(WRAP_M);
  assign diff_sh = diff_r >> lvl_r;
  assign lvl_m1  = lvl_r - LVLW'(1);

  always_comb begin
    case (uw.cond)
      lcabl_pkg::COND_IS_LOAD:   jump = is_load_r;
      lcabl_pkg::COND_LVL_NZ:    jump = (lvl_r != '0);
      lcabl_pkg::COND_A_EQ_B:    jump = (a_r == b_r);
      lcabl_pkg::COND_J_NLAST:   jump = (j_r != J_LAST);
      lcabl_pkg::COND_LVL_NLAST: jump = (lvl_r != LVL_TOP);
      lcabl_pkg::COND_ONE_LEVEL: jump = (LEVELS == 1);
      default:                   jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    is_load_nxt   = is_load_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dep_in_nxt    = dep_in_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    t_nxt         = t_r;
    da_nxt        = da_r;
    diff_nxt      = diff_r;
    lvl_nxt       = lvl_r;
    j_nxt         = j_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_node_nxt  = out_node_r;
    dep_we        = 1'b0;
    dep_raddr     = IW'(a_r);
    anc_we        = 1'b0;
    anc_waddr     = anc_addr('0, IW'(a_r));
    anc_wdata     = b_r;
    anc_raddr     = anc_addr(lvl_r, IW'(a_r));

    if (!busy_r) begin
      if (take) begin
        busy_nxt    = 1'b1;
        pc_nxt      = (in_opcode == lcabl_pkg::OP_BUILD) ? lcabl_pkg::PC_BUILD
                                                         : lcabl_pkg::PC_ENTRY;
        is_load_nxt = (in_opcode == lcabl_pkg::OP_LOAD);
        x_nxt       = in_node;
        y_nxt       = in_other_node;
        dep_in_nxt  = in_node_depth;
      end
    end else begin
      case (uw.act)
        lcabl_pkg::ACT_WRAP_Q: begin
          qa_nxt = prod_a[29:20];
          qb_nxt = prod_b[29:20];
        end
        lcabl_pkg::ACT_WRAP_R: begin
          a_nxt = x_r - NW'(qa_r * NODES_NW);
          b_nxt = y_r - NW'(qb_r * NODES_NW);
        end
        lcabl_pkg::ACT_LOAD: begin
          dep_we = 1'b1;
          anc_we = 1'b1;
        end
        lcabl_pkg::ACT_RD_DA: begin
          dep_raddr = IW'(a_r);
        end
        lcabl_pkg::ACT_RD_DB: begin
          da_nxt    = dep_rdata;
          dep_raddr = IW'(b_r);
        end
        lcabl_pkg::ACT_ORDER: begin
          lvl_nxt = LVL_TOP;
          if (da_r < dep_rdata) begin
            a_nxt    = b_r;
            b_nxt    = a_r;
            diff_nxt = dep_rdata - da_r;
          end else begin
            diff_nxt = da_r - dep_rdata;
          end
        end
        lcabl_pkg::ACT_LIFT_RD, lcabl_pkg::ACT_JRD_A: begin
          anc_raddr = anc_addr(lvl_r, IW'(a_r));
        end
        lcabl_pkg::ACT_LIFT_WB: begin
          if (diff_sh[0]) begin
            a_nxt = anc_rdata;
          end
          if (lvl_r != '0) begin
            lvl_nxt = lvl_m1;
          end
        end
        lcabl_pkg::ACT_EQ_CHK: begin
          lvl_nxt = LVL_TOP;
        end
        lcabl_pkg::ACT_JRD_B: begin
          t_nxt     = anc_rdata;
          anc_raddr = anc_addr(lvl_r, IW'(b_r));
        end
        lcabl_pkg::ACT_JUMP: begin
          if (t_r != anc_rdata) begin
            a_nxt = t_r;
            b_nxt = anc_rdata;
          end
          if (lvl_r != '0) begin
            lvl_nxt = lvl_m1;
          end
        end
        lcabl_pkg::ACT_FIN_RD: begin
          anc_raddr = anc_addr('0, IW'(a_r));
        end
        lcabl_pkg::ACT_FIN_OUT: begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = lcabl_pkg::KIND_ANSWER;
          out_node_nxt  = anc_rdata;
        end
        lcabl_pkg::ACT_OUT_A: begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = lcabl_pkg::KIND_ANSWER;
          out_node_nxt  = a_r;
        end
        lcabl_pkg::ACT_BINIT: begin
          lvl_nxt = LVLW'(1);
          j_nxt   = '0;
        end
        lcabl_pkg::ACT_BRD1: begin
          anc_raddr = anc_addr(lvl_m1, j_r);
        end
        lcabl_pkg::ACT_BRD2: begin
          anc_raddr = anc_addr(lvl_m1, IW'(anc_rdata));
        end
        lcabl_pkg::ACT_BWR: begin
          anc_we    = 1'b1;
          anc_waddr = anc_addr(lvl_r, j_r);
          anc_wdata = anc_rdata;
          if (j_r != J_LAST) begin
            j_nxt = j_r + IW'(1);
          end
        end
        lcabl_pkg::ACT_BNEXT: begin
          j_nxt   = '0;
          lvl_nxt = lvl_r + LVLW'(1);
        end
        lcabl_pkg::ACT_BDONE: begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = lcabl_pkg::KIND_BUILT;
          out_node_nxt  = '0;
        end
        default: begin
        end
      endcase

      if (uw.cond == lcabl_pkg::COND_END) begin
        busy_nxt = 1'b0;
        pc_nxt   = lcabl_pkg::PC_ENTRY;
      end else if (jump) begin
        pc_nxt = uw.target;
      end else begin
        pc_nxt = pc_r + lcabl_pkg::PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= lcabl_pkg::PC_ENTRY;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_load_r  <= is_load_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    dep_in_r   <= dep_in_nxt;
    qa_r       <= qa_nxt;
    qb_r       <= qb_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    t_r        <= t_nxt;
    da_r       <= da_nxt;
    diff_r     <= diff_nxt;
    lvl_r      <= lvl_nxt;
    j_r        <= j_nxt;
    out_kind_r <= out_kind_nxt;
    out_node_r <= out_node_nxt;
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_answer_node = out_node_r;

`include "lca_binary_lifting_unit_defines.svh"

  `LCABL_ASSERT_SAME(a_result_when_idle, clk, rst_n, out_valid_r, !busy_r,
                     "result beat while a command is still running")
  `LCABL_ASSERT_NEXT(a_single_beat, clk, rst_n, out_valid_r, !out_valid_r,
                     "result beat lasted more than one cycle")
  `LCABL_ASSERT_NEXT(a_accept_busy, clk, rst_n, take, busy_r && !out_valid_r,
                     "accepted command did not start the sequencer")
  `LCABL_ASSERT_SAME(a_load_silent, clk, rst_n,
                     busy_r && is_load_r && (pc_r == lcabl_pkg::PC_LOAD),
                     !out_valid_nxt, "load command produced a result")

endmodule
